/* rtl/pcfs_pkg.sv */
// Shared types, constants and tables for the pulse channel frame sequencer.
`default_nettype none

package pcfs_pkg;

  // Prescaler and frame counter sizing
  localparam int PRESCALE_DIV = 6;
  localparam int FRAME_WRAP   = 14916;
  localparam int PRESCALE_W   = 3;
  localparam int FRAME_W      = 14;

  // Frame counter points that raise quarter and half flags
  localparam logic [FRAME_W-1:0] FRAME_Q1   = FRAME_W'(3729);
  localparam logic [FRAME_W-1:0] FRAME_Q2   = FRAME_W'(7457);
  localparam logic [FRAME_W-1:0] FRAME_Q3   = FRAME_W'(11186);
  localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(FRAME_WRAP);

  // Request commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Register offsets and per-channel sub-registers
  localparam logic [4:0] OFF_STATUS = 5'h15;
  localparam logic [1:0] SUB_CTRL   = 2'd0;
  localparam logic [1:0] SUB_SWEEP  = 2'd1;
  localparam logic [1:0] SUB_TLO    = 2'd2;
  localparam logic [1:0] SUB_THI    = 2'd3;

  // Length load values, indexed by bits 7:3 of the timer-high write
  localparam logic [7:0] LEN_TABLE [32] = '{
    8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  typedef struct packed {
    logic       command;
    logic [4:0] reg_offset;
    logic [7:0] wdata;
  } req_t;

  typedef struct packed {
    logic        quarter_frame;
    logic        half_frame;
    logic        ch1_active;
    logic        ch2_active;
    logic [7:0]  ch1_len;
    logic [7:0]  ch2_len;
    logic [7:0]  ch1_pattern;
    logic [7:0]  ch2_pattern;
    logic [3:0]  ch1_vol;
    logic [3:0]  ch2_vol;
    logic [10:0] ch1_period;
    logic [10:0] ch2_period;
  } res_t;

  typedef struct packed {
    logic quarter;
    logic half;
  } frame_flags_t;

  typedef struct packed {
    logic        active;
    logic [7:0]  len;
    logic [7:0]  pattern;
    logic [3:0]  vol;
    logic [10:0] period;
  } chan_view_t;

  // Map duty code to its eight-step waveform
  function automatic logic [7:0] duty_pattern(input logic [1:0] duty);
    logic [7:0] pat;
    unique case (duty)
      2'd0:    pat = 8'b0000_0001;
      2'd1:    pat = 8'b0000_0011;
      2'd2:    pat = 8'b0000_1111;
      default: pat = 8'b1111_1100;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

/* rtl/pcfs_frame_seq.sv */
// Tick prescaler and frame counter that produce quarter and half frame flags.
`default_nettype none

module pcfs_frame_seq
  import pcfs_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         tick_i,
  output frame_flags_t      flags_o
);

  localparam logic [PRESCALE_W-1:0] DivCode = PRESCALE_W'(PRESCALE_DIV);

  logic [PRESCALE_W-1:0] prescale_q, prescale_d, pre_cur, pre_inc;
  logic [FRAME_W-1:0]    frame_q, frame_d, frame_inc;
  logic                  fire;

  // Advance prescaler and step the frame counter when it fires
  always_comb begin
    pre_cur   = (prescale_q >= DivCode) ? '0 : prescale_q;
    pre_inc   = pre_cur + PRESCALE_W'(1);
    fire      = (pre_cur == '0);
    frame_inc = frame_q + FRAME_W'(1);
    prescale_d = prescale_q;
    frame_d    = frame_q;
    flags_o    = '0;
    if (tick_i) begin
      prescale_d = (pre_inc >= DivCode) ? '0 : pre_inc;
      if (fire) begin
        frame_d = frame_inc;
        if (frame_inc == FRAME_Q1 || frame_inc == FRAME_Q3) begin
          flags_o.quarter = 1'b1;
        end
        if (frame_inc == FRAME_Q2) begin
          flags_o.quarter = 1'b1;
          flags_o.half    = 1'b1;
        end
        if (frame_inc == FRAME_LAST) begin
          flags_o.quarter = 1'b1;
          flags_o.half    = 1'b1;
          frame_d         = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
      frame_q    <= '0;
    end else begin
      prescale_q <= prescale_d;
      frame_q    <= frame_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/pcfs_chan_regs.sv */
// Register file and length counters for both pulse channels.
`default_nettype none

module pcfs_chan_regs
  import pcfs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [4:0]       offset_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic             half_i,
  output chan_view_t [1:0]      view_o
);

  logic [7:0]  pattern_q [2];
  logic [7:0]  pattern_d [2];
  logic        halt_q    [2];
  logic        halt_d    [2];
  logic [3:0]  vol_q     [2];
  logic [3:0]  vol_d     [2];
  logic [10:0] period_q  [2];
  logic [10:0] period_d  [2];
  logic [7:0]  len_q     [2];
  logic [7:0]  len_d     [2];
  logic        en_q      [2];
  logic        en_d      [2];

  // Decode the write, then apply the half-frame length decrement
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      pattern_d[c] = pattern_q[c];
      halt_d[c]    = halt_q[c];
      vol_d[c]     = vol_q[c];
      period_d[c]  = period_q[c];
      len_d[c]     = len_q[c];
      en_d[c]      = en_q[c];
      if (wr_i) begin
        if (offset_i[4:3] == 2'b00 && offset_i[2] == c[0]) begin
          unique case (offset_i[1:0])
            SUB_CTRL: begin
              pattern_d[c] = duty_pattern(wdata_i[7:6]);
              halt_d[c]    = wdata_i[5];
              vol_d[c]     = wdata_i[3:0];
            end
            SUB_SWEEP: begin
            end
            SUB_TLO: begin
              period_d[c] = {period_q[c][10:8], wdata_i};
            end
            SUB_THI: begin
              period_d[c] = {wdata_i[2:0], period_q[c][7:0]};
              len_d[c]    = LEN_TABLE[wdata_i[7:3]];
            end
            default: begin
            end
          endcase
        end else if (offset_i == OFF_STATUS) begin
          en_d[c] = wdata_i[c[0]];
          if (!wdata_i[c[0]]) begin
            len_d[c] = '0;
          end
        end
      end
      if (half_i && !halt_q[c] && len_q[c] != '0) begin
        len_d[c] = len_q[c] - 8'd1;
      end
      view_o[c].active  = en_d[c] && (len_d[c] != '0);
      view_o[c].len     = len_d[c];
      view_o[c].pattern = pattern_d[c];
      view_o[c].vol     = vol_d[c];
      view_o[c].period  = period_d[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        pattern_q[c] <= '0;
        halt_q[c]    <= 1'b0;
        vol_q[c]     <= '0;
        period_q[c]  <= '0;
        len_q[c]     <= '0;
        en_q[c]      <= 1'b0;
      end
    end else begin
      for (int c = 0; c < 2; c++) begin
        pattern_q[c] <= pattern_d[c];
        halt_q[c]    <= halt_d[c];
        vol_q[c]     <= vol_d[c];
        period_q[c]  <= period_d[c];
        len_q[c]     <= len_d[c];
        en_q[c]      <= en_d[c];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/pulse_channel_regs_frame_sequencer_unit.sv */
// Top level of the pulse channel register file and frame sequencer.
//
//   channel | direction | payload | handshake
//   in      | input     | req_t   | in_valid_i / in_ready_o
//   out     | output    | res_t   | out_valid_o / out_ready_i
//
// Each request is captured in an input register; when a result slot is free,
// the channel registers and frame sequencer update and the result register
// loads. One request per cycle is sustained unless the output stalls.
// Reset clears all channel state, the prescaler and the frame counter.
// A stalled output holds the result; the input register still takes one more
// request, and state advances only when a result register slot is free.
`default_nettype none

module pulse_channel_regs_frame_sequencer_unit
  import pcfs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_res_o
);

  logic             in_valid_q;
  req_t             req_q;
  logic             step;
  frame_flags_t     flags;
  chan_view_t [1:0] view;
  res_t             res_d;

  // Advance the request into the result register when a slot is free
  assign step       = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  // Hold the accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  pcfs_frame_seq u_frame_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (step && req_q.command == CMD_TICK),
    .flags_o (flags)
  );

  pcfs_chan_regs u_chan_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (step && req_q.command == CMD_WRITE),
    .offset_i (req_q.reg_offset),
    .wdata_i  (req_q.wdata),
    .half_i   (flags.half),
    .view_o   (view)
  );

  // Assemble the result from the updated state
  always_comb begin
    res_d.quarter_frame = flags.quarter;
    res_d.half_frame    = flags.half;
    res_d.ch1_active    = view[0].active;
    res_d.ch2_active    = view[1].active;
    res_d.ch1_len       = view[0].len;
    res_d.ch2_len       = view[1].len;
    res_d.ch1_pattern   = view[0].pattern;
    res_d.ch2_pattern   = view[1].pattern;
    res_d.ch1_vol       = view[0].vol;
    res_d.ch2_vol       = view[1].vol;
    res_d.ch1_period    = view[0].period;
    res_d.ch2_period    = view[1].period;
  end

  // Load or drop the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (step) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_o <= res_d;
    end
  end

  // A half frame is always also a quarter frame
  a_half_has_quarter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_res_o.half_frame || out_res_o.quarter_frame))
    else $error("half frame without quarter frame");

  // Write requests never raise frame flags
  a_write_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && req_q.command == CMD_WRITE) |=>
      (!out_res_o.quarter_frame && !out_res_o.half_frame))
    else $error("frame flag on a write request");

  // An active channel has a nonzero length
  a_active_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((!out_res_o.ch1_active || out_res_o.ch1_len != 8'd0) &&
                     (!out_res_o.ch2_active || out_res_o.ch2_len != 8'd0)))
    else $error("active channel with zero length");

  // A held request blocks new input while the output is stalled
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while request register is full");

endmodule

`default_nettype wire

/* tb/pulse_frame_sb_pkg.sv */
// Scoreboard class that predicts pulse channel and frame sequencer results and checks them.
package pulse_frame_sb_pkg;
  import pcfs_pkg::*;

  // Frame counter points that raise the flags
  localparam logic [13:0] QUARTER_A = 14'd3729;
  localparam logic [13:0] HALF_A    = 14'd7457;
  localparam logic [13:0] QUARTER_B = 14'd11186;

  // Eight-step waveforms per duty code
  localparam logic [7:0] DUTY_WAVE [4] = '{8'h01, 8'h03, 8'h0F, 8'hFC};

  // Length load values by index, entry 28 corrected to 16
  localparam logic [7:0] LEN_LOAD [32] = '{
    8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  class pulse_frame_scoreboard;
    logic [2:0]  presc_cnt;
    logic [13:0] frame_cnt;
    logic [7:0]  wave[2];
    logic        halted[2];
    logic [3:0]  vol[2];
    logic [10:0] timer_reload[2];
    logic [7:0]  len_cnt[2];
    logic        chan_en[2];
    res_t        expected_res[$];
    int          errors;
    int          results_seen;

    function new();
      presc_cnt = '0;
      frame_cnt = '0;
      for (int c = 0; c < 2; c++) begin
        wave[c] = '0;
        halted[c] = 1'b0;
        vol[c] = '0;
        timer_reload[c] = '0;
        len_cnt[c] = '0;
        chan_en[c] = 1'b0;
      end
      errors = 0;
      results_seen = 0;
    endfunction

    // Apply one request to the channel state and build the result it causes
    function res_t next_result(req_t r);
      res_t e;
      logic qf;
      logic hf;
      int   c;
      qf = 1'b0;
      hf = 1'b0;
      if (r.command == CMD_WRITE) begin
        if (r.reg_offset < 5'd8) begin
          c = r.reg_offset[2];
          case (r.reg_offset[1:0])
            SUB_CTRL: begin
              wave[c] = DUTY_WAVE[r.wdata[7:6]];
              halted[c] = r.wdata[5];
              vol[c] = r.wdata[3:0];
            end
            SUB_TLO: begin
              timer_reload[c][7:0] = r.wdata;
            end
            SUB_THI: begin
              timer_reload[c][10:8] = r.wdata[2:0];
              len_cnt[c] = LEN_LOAD[r.wdata[7:3]];
            end
            default: begin
            end
          endcase
        end else if (r.reg_offset == OFF_STATUS) begin
          for (c = 0; c < 2; c++) begin
            chan_en[c] = r.wdata[c];
            if (!chan_en[c]) len_cnt[c] = '0;
          end
        end
      end else begin
        if (presc_cnt >= PRESCALE_DIV) presc_cnt = '0;
        if (presc_cnt == 3'd0) begin
          frame_cnt = frame_cnt + 14'd1;
          if (frame_cnt == QUARTER_A || frame_cnt == QUARTER_B) qf = 1'b1;
          if (frame_cnt == HALF_A) begin
            qf = 1'b1;
            hf = 1'b1;
          end
          if (frame_cnt == FRAME_WRAP) begin
            qf = 1'b1;
            hf = 1'b1;
            frame_cnt = '0;
          end
          // Count down unhalted lengths on half frame
          if (hf) begin
            for (c = 0; c < 2; c++) begin
              if (!halted[c] && len_cnt[c] != 8'd0) len_cnt[c] = len_cnt[c] - 8'd1;
            end
          end
        end
        presc_cnt = presc_cnt + 3'd1;
        if (presc_cnt >= PRESCALE_DIV) presc_cnt = '0;
      end
      e.quarter_frame = qf;
      e.half_frame = hf;
      e.ch1_active = chan_en[0] && (len_cnt[0] != 8'd0);
      e.ch2_active = chan_en[1] && (len_cnt[1] != 8'd0);
      e.ch1_len = len_cnt[0];
      e.ch2_len = len_cnt[1];
      e.ch1_pattern = wave[0];
      e.ch2_pattern = wave[1];
      e.ch1_vol = vol[0];
      e.ch2_vol = vol[1];
      e.ch1_period = timer_reload[0];
      e.ch2_period = timer_reload[1];
      return e;
    endfunction

    function void note_request(req_t r);
      expected_res.push_back(next_result(r));
    endfunction

    function int pending();
      return expected_res.size();
    endfunction

    // Count one mismatch and print its line for the first 40 only
    task report(string what);
      errors++;
      if (errors <= 40) $display("ERROR: %s", what);
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s: got %0d, expected %0d", results_seen, name, got, want));
      end
    endtask

    // Compare one result with the oldest prediction
    task check_result(res_t got);
      res_t want;
      if (expected_res.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected: %h", results_seen, got));
        results_seen++;
        return;
      end
      want = expected_res.pop_front();
      check_field("quarter_frame", got.quarter_frame, want.quarter_frame);
      check_field("half_frame", got.half_frame, want.half_frame);
      check_field("ch1_active", got.ch1_active, want.ch1_active);
      check_field("ch2_active", got.ch2_active, want.ch2_active);
      check_field("ch1_len", got.ch1_len, want.ch1_len);
      check_field("ch2_len", got.ch2_len, want.ch2_len);
      check_field("ch1_pattern", got.ch1_pattern, want.ch1_pattern);
      check_field("ch2_pattern", got.ch2_pattern, want.ch2_pattern);
      check_field("ch1_vol", got.ch1_vol, want.ch1_vol);
      check_field("ch2_vol", got.ch2_vol, want.ch2_vol);
      check_field("ch1_period", got.ch1_period, want.ch1_period);
      check_field("ch2_period", got.ch2_period, want.ch2_period);
      results_seen++;
    endtask
  endclass

endpackage

/* tb/tb.sv */
// Top-level testbench: drives requests and checks results of the frame sequencer unit.
module tb;
  import pcfs_pkg::*;
  import pulse_frame_sb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RAND_ITEMS  = 700;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  res_t out_res_o;

  pulse_frame_scoreboard sb = new();

  int items_sent;
  int calm_left;

  pulse_channel_regs_frame_sequencer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic req_t mk_req(logic cmd, logic [4:0] off, logic [7:0] d);
    req_t r;
    r.command = cmd;
    r.reg_offset = off;
    r.wdata = d;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Maybe idle the sender, then present one request and hold it until accepted
  task push(req_t r);
    int gap;
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else if ($urandom_range(0, 99) == 0) begin
      calm_left = $urandom_range(30, 200);
    end else begin
      gap = pick_gap();
    end
    items_sent++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
  endtask

  // Hold off the sender until every predicted result has arrived
  task drain_wait();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task tick_burst(int n);
    for (int i = 0; i < n; i++) begin
      push(mk_req(CMD_TICK, 5'($urandom), 8'($urandom)));
    end
  endtask

  // Program one channel: control, timer lo/hi with length load, often a status write
  task program_channel();
    logic [4:0] base;
    logic [7:0] thi;
    base = $urandom_range(0, 1) ? 5'd4 : 5'd0;
    thi = 8'($urandom);
    if ($urandom_range(0, 2) == 0) thi[7:3] = $urandom_range(0, 1) ? 5'd3 : 5'd5;
    push(mk_req(CMD_WRITE, base | 5'(SUB_CTRL), 8'($urandom)));
    push(mk_req(CMD_WRITE, base | 5'(SUB_TLO), 8'($urandom)));
    push(mk_req(CMD_WRITE, base | 5'(SUB_THI), thi));
    if ($urandom_range(0, 9) < 6) begin
      push(mk_req(CMD_WRITE, OFF_STATUS,
                  {6'($urandom), ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'b11}));
    end
  endtask

  task run_directed();
    push(mk_req(CMD_TICK, 5'h00, 8'h00));
    push(mk_req(CMD_WRITE, 5'h00, 8'hFF));
    push(mk_req(CMD_WRITE, 5'h04, 8'h00));
    push(mk_req(CMD_WRITE, 5'h02, 8'hFF));
    push(mk_req(CMD_WRITE, 5'h06, 8'h00));
    // Length index 28 loads the corrected value
    push(mk_req(CMD_WRITE, 5'h03, {5'd28, 3'b111}));
    push(mk_req(CMD_WRITE, 5'h07, {5'd1, 3'b000}));
    push(mk_req(CMD_WRITE, OFF_STATUS, 8'h03));
    push(mk_req(CMD_WRITE, 5'h01, 8'hFF));
    push(mk_req(CMD_WRITE, 5'h05, 8'hAA));
    // Unmapped offsets change nothing
    push(mk_req(CMD_WRITE, 5'h08, 8'hFF));
    push(mk_req(CMD_WRITE, 5'h1F, 8'hFF));
    push(mk_req(CMD_WRITE, 5'h14, 8'h55));
    push(mk_req(CMD_WRITE, 5'h16, 8'hAA));
    // Run the prescaler through a full wrap and one more firing
    for (int i = 0; i < 7; i++) push(mk_req(CMD_TICK, 5'h1F, 8'hFF));
    push(mk_req(CMD_WRITE, OFF_STATUS, 8'h01));
    push(mk_req(CMD_WRITE, OFF_STATUS, 8'hFE));
    push(mk_req(CMD_WRITE, 5'h00, 8'h40));
    push(mk_req(CMD_WRITE, 5'h04, 8'h80));
    push(mk_req(CMD_WRITE, 5'h07, 8'hF8));
  endtask

  task run_random();
    int p;
    while (items_sent < RAND_ITEMS + 25) begin
      p = $urandom_range(0, 99);
      if (p < 45) begin
        program_channel();
      end else if (p < 72) begin
        tick_burst($urandom_range(1, 40));
      end else if (p < 92) begin
        push(mk_req(CMD_WRITE, 5'($urandom), 8'($urandom)));
      end else if (p < 97) begin
        push(mk_req(CMD_WRITE, OFF_STATUS, 8'($urandom)));
      end else begin
        drain_wait();
      end
    end
  endtask

  // Main sequence
  initial begin
    items_sent = 0;
    calm_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    drain_wait();
    run_random();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Check results and stall the receiver at random
  initial begin
    int stall_left;
    int quiet_left;
    int p;
    stall_left = 0;
    quiet_left = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_res_o);
      if (quiet_left > 0) begin
        quiet_left--;
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 999) == 0) begin
          quiet_left = $urandom_range(200, 800);
        end else if ($urandom_range(0, 99) < 12) begin
          p = $urandom_range(0, 99);
          if (p < 70) stall_left = $urandom_range(1, 2);
          else if (p < 95) stall_left = $urandom_range(3, 8);
          else stall_left = $urandom_range(20, 40);
        end
      end
    end
  end

  // Abort when neither channel moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
